// ===== hdl/ibe_pkg.sv =====
// Shared types and constants for the I2C master byte engine.
package ibe_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // One tick as it travels from the front to the back.
  typedef struct packed {
    logic       cmd_valid;
    op_t        op;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam int PHASE_W     = 3;
  localparam int TICK_W      = 16;
  localparam int BIT_CNT_W   = 4;
  localparam int BYTE_W      = 8;

  localparam logic [TICK_W-1:0]    PHASE_TICKS_RESET = 16'd50;
  localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE     = 4'd8;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_PHASE_TICKS = 3'd0;

endpackage

// ===== hdl/ibe_front.sv =====
// Front end: takes tick transfers, decodes the opcode and queues them for the engine.
module ibe_front import ibe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       cmd_valid,
  input  logic [1:0] opcode,
  input  logic [7:0] tx_byte,
  input  logic       send_ack,
  input  logic       sda_in,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  item_t             q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] q_count;
  logic              push;
  logic              pop;
  item_t             in_item;

  always_comb begin
    in_item.cmd_valid = cmd_valid;
    in_item.op        = op_t'(opcode);
    in_item.tx_byte   = tx_byte;
    in_item.send_ack  = send_ack;
    in_item.sda_in    = sda_in;
  end

  assign in_stall = (q_count == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (q_count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   q_count <= q_count + QCNT_W'(1);
        2'b01:   q_count <= q_count - QCNT_W'(1);
        default: q_count <= q_count;
      endcase
    end
  end

endmodule

// ===== hdl/ibe_back.sv =====
// Back end: the phase sequencer that advances one tick per queued transfer.
module ibe_back import ibe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  input  logic [TICK_W-1:0] phase_ticks,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              scl_level,
  output logic              sda_level,
  output logic              sda_drive,
  output logic              busy_res,
  output logic              done_res,
  output logic [7:0]        rx_byte,
  output logic              slave_ack
);

  op_t                  kind, kind_next;
  logic [PHASE_W-1:0]   phase, phase_next;
  logic [BIT_CNT_W-1:0] bit_cnt, bit_cnt_next;
  logic [TICK_W-1:0]    tick_cnt, tick_cnt_next;
  logic [BYTE_W-1:0]    shift, shift_next;
  logic                 ack_choice, ack_choice_next;
  logic                 busy, busy_next;
  logic                 scl, scl_next;
  logic                 sda, sda_next;
  logic                 sda_drv, sda_drv_next;
  logic [BYTE_W-1:0]    rx, rx_next;
  logic                 ack, ack_next;
  logic                 done_next;

  logic                 take;
  logic [TICK_W-1:0]    limit;
  logic [TICK_W-1:0]    tick_inc;
  logic                 do_enter;
  logic [PHASE_W-1:0]   enter_p;
  logic                 finish;

  // Take a tick whenever the output register is empty or being drained.
  assign take  = q_valid && (!out_valid || !out_stall);
  assign q_pop = take;

  assign limit    = (phase_ticks == '0) ? TICK_W'(1) : phase_ticks;
  assign tick_inc = tick_cnt + TICK_W'(1);

  always_comb begin
    kind_next       = kind;
    phase_next      = phase;
    bit_cnt_next    = bit_cnt;
    tick_cnt_next   = tick_cnt;
    shift_next      = shift;
    ack_choice_next = ack_choice;
    busy_next       = busy;
    scl_next        = scl;
    sda_next        = sda;
    sda_drv_next    = sda_drv;
    rx_next         = rx;
    ack_next        = ack;
    done_next       = 1'b0;
    do_enter        = 1'b0;
    enter_p         = '0;
    finish          = 1'b0;

    if (busy) begin
      tick_cnt_next = tick_inc;
      if (tick_inc >= limit) begin
        case (kind)
          OP_START, OP_STOP: begin
            if (phase >= PHASE_W'(2)) begin
              finish = 1'b1;
            end else begin
              do_enter = 1'b1;
              enter_p  = phase + PHASE_W'(1);
            end
          end
          OP_WRITE: begin
            if (phase == PHASE_W'(2)) begin
              shift_next   = {shift[BYTE_W-2:0], 1'b0};
              bit_cnt_next = bit_cnt + BIT_CNT_W'(1);
              do_enter     = 1'b1;
              enter_p      = (bit_cnt_next < BITS_PER_BYTE) ? PHASE_W'(0) : PHASE_W'(3);
            end else if (phase >= PHASE_W'(5)) begin
              scl_next = 1'b0;
              finish   = 1'b1;
            end else begin
              if (phase == PHASE_W'(4)) begin
                ack_next = q_item.sda_in;
              end
              do_enter = 1'b1;
              enter_p  = phase + PHASE_W'(1);
            end
          end
          default: begin
            if (phase == PHASE_W'(0)) begin
              shift_next = {shift[BYTE_W-2:0], q_item.sda_in};
              do_enter   = 1'b1;
              enter_p    = PHASE_W'(1);
            end else if (phase == PHASE_W'(1)) begin
              bit_cnt_next = bit_cnt + BIT_CNT_W'(1);
              do_enter     = 1'b1;
              enter_p      = (bit_cnt_next < BITS_PER_BYTE) ? PHASE_W'(0) : PHASE_W'(2);
            end else if (phase >= PHASE_W'(4)) begin
              if (ack_choice) begin
                sda_next = 1'b1;
              end
              rx_next = shift;
              finish  = 1'b1;
            end else begin
              do_enter = 1'b1;
              enter_p  = phase + PHASE_W'(1);
            end
          end
        endcase
      end
      if (finish) begin
        busy_next     = 1'b0;
        done_next     = 1'b1;
        tick_cnt_next = '0;
        phase_next    = '0;
        bit_cnt_next  = '0;
      end
    end else if (q_item.cmd_valid) begin
      kind_next       = q_item.op;
      ack_choice_next = q_item.send_ack;
      shift_next      = (q_item.op == OP_WRITE) ? q_item.tx_byte : '0;
      bit_cnt_next    = '0;
      busy_next       = 1'b1;
      do_enter        = 1'b1;
      enter_p         = '0;
    end

    // Apply the line levels of the phase being entered.
    if (do_enter) begin
      phase_next    = enter_p;
      tick_cnt_next = '0;
      case (kind_next)
        OP_START: begin
          if (enter_p == PHASE_W'(0)) begin
            sda_next     = 1'b1;
            scl_next     = 1'b1;
            sda_drv_next = 1'b1;
          end else if (enter_p == PHASE_W'(1)) begin
            sda_next = 1'b0;
          end else begin
            scl_next = 1'b0;
          end
        end
        OP_STOP: begin
          if (enter_p == PHASE_W'(0)) begin
            sda_next     = 1'b0;
            sda_drv_next = 1'b1;
          end else if (enter_p == PHASE_W'(1)) begin
            scl_next = 1'b1;
          end else begin
            sda_next = 1'b1;
          end
        end
        OP_WRITE: begin
          if (enter_p == PHASE_W'(0)) begin
            sda_next     = shift_next[BYTE_W-1];
            sda_drv_next = 1'b1;
          end else if (enter_p == PHASE_W'(1) || enter_p == PHASE_W'(4)) begin
            scl_next = 1'b1;
          end else if (enter_p == PHASE_W'(2)) begin
            scl_next = 1'b0;
          end else if (enter_p == PHASE_W'(3)) begin
            sda_next     = 1'b1;
            sda_drv_next = 1'b0;
          end else begin
            sda_drv_next = 1'b1;
          end
        end
        default: begin
          if (enter_p == PHASE_W'(0)) begin
            scl_next     = 1'b1;
            sda_drv_next = 1'b0;
          end else if (enter_p == PHASE_W'(1) || enter_p == PHASE_W'(4)) begin
            scl_next = 1'b0;
          end else if (enter_p == PHASE_W'(2)) begin
            sda_drv_next = 1'b1;
            sda_next     = !ack_choice_next;
          end else begin
            scl_next = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind       <= OP_START;
      phase      <= '0;
      bit_cnt    <= '0;
      tick_cnt   <= '0;
      shift      <= '0;
      ack_choice <= 1'b0;
      busy       <= 1'b0;
      scl        <= 1'b1;
      sda        <= 1'b1;
      sda_drv    <= 1'b1;
      rx         <= '0;
      ack        <= 1'b1;
      done_res   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        kind       <= kind_next;
        phase      <= phase_next;
        bit_cnt    <= bit_cnt_next;
        tick_cnt   <= tick_cnt_next;
        shift      <= shift_next;
        ack_choice <= ack_choice_next;
        busy       <= busy_next;
        scl        <= scl_next;
        sda        <= sda_next;
        sda_drv    <= sda_drv_next;
        rx         <= rx_next;
        ack        <= ack_next;
        done_res   <= done_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign scl_level = scl;
  assign sda_level = sda;
  assign sda_drive = sda_drv;
  assign busy_res  = busy;
  assign rx_byte   = rx;
  assign slave_ack = ack;

endmodule

// ===== hdl/i2c_master_byte_engine.sv =====
// Top level of the I2C master byte engine: front queue, phase sequencer, APB register.
//
// Each input transfer is one tick of the bus engine: it carries an optional
// command (start, stop, write byte, read byte with ACK/NACK choice) and the
// sampled SDA level, and it yields exactly one output transfer with the SCL,
// SDA and SDA-drive levels after that tick, the busy flag, a done pulse on
// the completing tick, the last received byte and the last sampled slave ACK.
// A command offered while the engine is busy (including on its completing
// tick) is dropped. Every phase of a command lasts phase_ticks ticks (a value
// of zero counts as one); the register sits at APB byte address 0, resets to
// 50 and should be written only while no tick transfer is outstanding.
// Throughput is one transfer per clock when neither side stalls: the
// sequencer evaluates a full tick in its combinational next-state logic.
// An input transfer is registered in the four-entry queue between the front
// and the sequencer, then in the output register. The queue absorbs output
// stalls, so in_stall rises only once four transfers are waiting.
module i2c_master_byte_engine import ibe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // tick input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cmd_valid,
  input  logic [1:0]            opcode,
  input  logic [7:0]            tx_byte,
  input  logic                  send_ack,
  input  logic                  sda_in,
  // tick result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  scl_level,
  output logic                  sda_level,
  output logic                  sda_drive,
  output logic                  busy_res,
  output logic                  done_res,
  output logic [7:0]            rx_byte,
  output logic                  slave_ack,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic              q_valid;
  item_t             q_item;
  logic              q_pop;
  logic [TICK_W-1:0] phase_ticks;
  logic              reg_write;

  // Accept a register write on the access cycle; the port never waits.
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RESET;
    end else if (reg_write && paddr == REG_PHASE_TICKS) begin
      phase_ticks <= pwdata[TICK_W-1:0];
    end
  end

  // Return the register on its address, zero elsewhere.
  assign prdata = (paddr == REG_PHASE_TICKS) ? APB_DATA_W'(phase_ticks) : '0;

  ibe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd_valid (cmd_valid),
    .opcode    (opcode),
    .tx_byte   (tx_byte),
    .send_ack  (send_ack),
    .sda_in    (sda_in),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  ibe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .phase_ticks (phase_ticks),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .scl_level   (scl_level),
    .sda_level   (sda_level),
    .sda_drive   (sda_drive),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .rx_byte     (rx_byte),
    .slave_ack   (slave_ack)
  );

endmodule

// ===== test/ibe_line_check.sv =====
`timescale 1ns / 1ps
// Tick-by-tick predictor and comparator for the I2C master byte engine.
module ibe_line_check import ibe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  cmd_valid,
  input  logic [1:0]            opcode,
  input  logic [7:0]            tx_byte,
  input  logic                  send_ack,
  input  logic                  sda_in,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  scl_level,
  input  logic                  sda_level,
  input  logic                  sda_drive,
  input  logic                  busy_res,
  input  logic                  done_res,
  input  logic [7:0]            rx_byte,
  input  logic                  slave_ack,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int                    errors,
  output int                    outstanding,
  output int                    completions
);

  typedef struct packed {
    logic              scl;
    logic              sda;
    logic              drive;
    logic              busy;
    logic              done;
    logic [BYTE_W-1:0] rx;
    logic              ack;
  } lines_t;

  lines_t expected_lines[$];
  lines_t popped;
  int     fail_tally = 0;
  int     done_tally = 0;

  assign errors      = fail_tally;
  assign completions = done_tally;

  // Private copy of the engine.
  logic [TICK_W-1:0]    ticks_per_phase;
  op_t                  cmd_kind;
  logic [4:0]           phase_at;
  logic [BIT_CNT_W-1:0] bit_at;
  logic [TICK_W-1:0]    tick_at;
  logic [BYTE_W-1:0]    shifter;
  logic                 ack_pick;
  logic                 busy_now;
  logic                 scl_now;
  logic                 sda_now;
  logic                 drive_now;
  logic [BYTE_W-1:0]    rx_last;
  logic                 ack_last;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    // Print the first few in full, count all of them.
    if (fail_tally < 40) begin
      $display("%0t line_check: %s got %h, predicted %h", $time, what, got, want);
    end
    fail_tally++;
  endtask

  // Apply the levels that a phase sets on entry.
  function automatic void begin_phase(input logic [4:0] p);
    phase_at = p;
    tick_at  = '0;
    case (cmd_kind)
      OP_START: begin
        if (p == 0) begin
          sda_now = 1'b1; scl_now = 1'b1; drive_now = 1'b1;
        end else if (p == 1) begin
          sda_now = 1'b0;
        end else begin
          scl_now = 1'b0;
        end
      end
      OP_STOP: begin
        if (p == 0) begin
          sda_now = 1'b0; drive_now = 1'b1;
        end else if (p == 1) begin
          scl_now = 1'b1;
        end else begin
          sda_now = 1'b1;
        end
      end
      OP_WRITE: begin
        if (p == 0) begin
          sda_now = shifter[BYTE_W-1]; drive_now = 1'b1;
        end else if (p == 1 || p == 4) begin
          scl_now = 1'b1;
        end else if (p == 2) begin
          scl_now = 1'b0;
        end else if (p == 3) begin
          sda_now = 1'b1; drive_now = 1'b0;
        end else begin
          drive_now = 1'b1;
        end
      end
      default: begin
        if (p == 0) begin
          scl_now = 1'b1; drive_now = 1'b0;
        end else if (p == 1 || p == 4) begin
          scl_now = 1'b0;
        end else if (p == 2) begin
          drive_now = 1'b1; sda_now = ack_pick ? 1'b0 : 1'b1;
        end else begin
          scl_now = 1'b1;
        end
      end
    endcase
  endfunction

  // Close the running phase; return 1 when the command is complete.
  function automatic bit finish_phase(input logic sda_smp);
    case (cmd_kind)
      OP_START, OP_STOP: begin
        if (phase_at >= 2) return 1'b1;
        begin_phase(phase_at + 5'd1);
        return 1'b0;
      end
      OP_WRITE: begin
        if (phase_at == 2) begin
          shifter = shifter << 1;
          bit_at  = bit_at + BIT_CNT_W'(1);
          begin_phase(bit_at < BITS_PER_BYTE ? 5'd0 : 5'd3);
          return 1'b0;
        end
        if (phase_at == 4) ack_last = sda_smp;
        if (phase_at >= 5) begin
          scl_now = 1'b0;
          return 1'b1;
        end
        begin_phase(phase_at + 5'd1);
        return 1'b0;
      end
      default: begin
        if (phase_at == 0) begin
          shifter = {shifter[BYTE_W-2:0], sda_smp};
          begin_phase(5'd1);
          return 1'b0;
        end
        if (phase_at == 1) begin
          bit_at = bit_at + BIT_CNT_W'(1);
          begin_phase(bit_at < BITS_PER_BYTE ? 5'd0 : 5'd2);
          return 1'b0;
        end
        if (phase_at >= 4) begin
          if (ack_pick) sda_now = 1'b1;
          rx_last = shifter;
          return 1'b1;
        end
        begin_phase(phase_at + 5'd1);
        return 1'b0;
      end
    endcase
  endfunction

  // Advance the engine copy by one tick and return the line levels after it.
  function automatic lines_t predict_tick(input logic cv, input logic [1:0] op,
                                          input logic [7:0] tx, input logic ack,
                                          input logic sda_smp);
    logic [TICK_W-1:0] limit;
    lines_t            r;
    limit  = (ticks_per_phase == '0) ? TICK_W'(1) : ticks_per_phase;
    r.done = 1'b0;
    if (busy_now) begin
      tick_at = tick_at + TICK_W'(1);
      if (tick_at >= limit) begin
        if (finish_phase(sda_smp)) begin
          busy_now = 1'b0;
          r.done   = 1'b1;
          tick_at  = '0;
          phase_at = '0;
          bit_at   = '0;
        end
      end
    end else if (cv) begin
      cmd_kind = op_t'(op);
      ack_pick = ack;
      shifter  = (op_t'(op) == OP_WRITE) ? tx : '0;
      bit_at   = '0;
      busy_now = 1'b1;
      begin_phase(5'd0);
    end
    r.scl   = scl_now;
    r.sda   = sda_now;
    r.drive = drive_now;
    r.busy  = busy_now;
    r.rx    = rx_last;
    r.ack   = ack_last;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      ticks_per_phase = PHASE_TICKS_RESET;
      cmd_kind  = OP_START;
      phase_at  = '0;
      bit_at    = '0;
      tick_at   = '0;
      shifter   = '0;
      ack_pick  = 1'b0;
      busy_now  = 1'b0;
      scl_now   = 1'b1;
      sda_now   = 1'b1;
      drive_now = 1'b1;
      rx_last   = '0;
      ack_last  = 1'b1;
      expected_lines.delete();
    end else begin
      if (psel && penable && pready && paddr == REG_PHASE_TICKS) begin
        if (pwrite) begin
          ticks_per_phase = pwdata[TICK_W-1:0];
        end else if (prdata !== {{(APB_DATA_W-TICK_W){1'b0}}, ticks_per_phase}) begin
          report_mismatch("prdata", prdata, 32'(ticks_per_phase));
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_lines.size() == 0) begin
          report_mismatch("result with nothing pending", 32'd1, 32'd0);
        end else begin
          popped = expected_lines.pop_front();
          if (scl_level !== popped.scl)
            report_mismatch("scl_level", 32'(scl_level), 32'(popped.scl));
          if (sda_level !== popped.sda)
            report_mismatch("sda_level", 32'(sda_level), 32'(popped.sda));
          if (sda_drive !== popped.drive)
            report_mismatch("sda_drive", 32'(sda_drive), 32'(popped.drive));
          if (busy_res !== popped.busy)
            report_mismatch("busy_res", 32'(busy_res), 32'(popped.busy));
          if (done_res !== popped.done)
            report_mismatch("done_res", 32'(done_res), 32'(popped.done));
          if (rx_byte !== popped.rx)
            report_mismatch("rx_byte", 32'(rx_byte), 32'(popped.rx));
          if (slave_ack !== popped.ack)
            report_mismatch("slave_ack", 32'(slave_ack), 32'(popped.ack));
          if (popped.done) done_tally++;
        end
      end
      if (in_valid && !in_stall) begin
        expected_lines.push_back(predict_tick(cmd_valid, opcode, tx_byte, send_ack, sda_in));
      end
    end
    outstanding <= expected_lines.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the I2C master byte engine testbench: stimulus, stalls and verdict.
module tb_top;
  import ibe_pkg::*;

  // Length of the one forced output hold, in cycles.
  localparam int LONG_HOLD = 64;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  cmd_valid = 1'b0;
  logic [1:0]            opcode    = 2'b00;
  logic [7:0]            tx_byte   = 8'h00;
  logic                  send_ack  = 1'b0;
  logic                  sda_in    = 1'b1;
  logic                  out_stall = 1'b0;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0] paddr     = '0;
  logic [APB_DATA_W-1:0] pwdata    = '0;

  logic                  in_stall;
  logic                  out_valid;
  logic                  scl_level;
  logic                  sda_level;
  logic                  sda_drive;
  logic                  busy_res;
  logic                  done_res;
  logic [7:0]            rx_byte;
  logic                  slave_ack;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int errors;
  int outstanding;
  int completions;

  // Sender bookkeeping: the phase length the engine runs with now, the
  // burst in progress and the tick transfers handed over so far.
  logic [TICK_W-1:0] pt_now     = PHASE_TICKS_RESET;
  int                burst_left = 0;
  bit                gaps_on    = 1'b1;
  int                ticks_sent = 0;

  // Receiver bookkeeping: long holds asked by the sender side and served here.
  int          hold_asked = 0;
  int          hold_given = 0;
  int          hold_left  = 0;
  int          mode_left  = 0;
  stall_mode_t stall_mode = STALL_NONE;

  i2c_master_byte_engine dut (.*);

  ibe_line_check line_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stretches of no stall, light stall and heavy stall, plus a long
  // hold whenever the sender asks for one, counted here in cycles.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_asked != hold_given) begin
      hold_given++;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 2));
        mode_left  = $urandom_range(16, 160);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        default:     out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Random byte and random bit at their own widths.
  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic rnd_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Plain tick: no command, every other field random so that the engine
  // must ignore it.
  function automatic item_t idle_tick();
    item_t t;
    t.cmd_valid = 1'b0;
    t.op        = op_t'($urandom_range(0, 3));
    t.tx_byte   = rnd_byte();
    t.send_ack  = rnd_bit();
    t.sda_in    = rnd_bit();
    return t;
  endfunction

  // Offer one tick transfer and hold it until it is taken. Between bursts,
  // drop valid for a random gap when gaps are enabled.
  task automatic put_tick(input item_t t);
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid  <= 1'b1;
    cmd_valid <= t.cmd_valid;
    opcode    <= t.op;
    tx_byte   <= t.tx_byte;
    send_ack  <= t.send_ack;
    sda_in    <= t.sda_in;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
  endtask

  // Stop offering, wait until every tick transfer has come back, then idle briefly.
  task automatic settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // One register access: setup cycle, access cycle, then release the bus.
  task automatic apb_access(input bit is_write, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= REG_PHASE_TICKS;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (is_write) pt_now = data[TICK_W-1:0];
    @(posedge clk);
  endtask

  // Issue a command, then feed idle ticks for as long as it runs. Start and
  // stop take three phases, a write 8*3+3, a read 8*2+3. While busy, some
  // ticks carry a stray command that must be dropped; hit_done puts one on
  // the completing tick. Slack ticks after completion stay clean.
  task automatic run_command(input op_t op, input logic [7:0] data, input logic ack,
                             input int noise_pct, input bit hit_done, input int slack);
    item_t t;
    int    span;
    t           = idle_tick();
    t.cmd_valid = 1'b1;
    t.op        = op;
    t.tx_byte   = data;
    t.send_ack  = ack;
    put_tick(t);
    case (op)
      OP_START, OP_STOP: span = 3;
      OP_WRITE:          span = 27;
      default:           span = 19;
    endcase
    span = span * ((pt_now == '0) ? 1 : int'(pt_now));
    for (int i = 1; i <= span + slack; i++) begin
      t = idle_tick();
      if (i < span && $urandom_range(0, 99) < noise_pct) t.cmd_valid = 1'b1;
      if (i == span && hit_done) t.cmd_valid = 1'b1;
      put_tick(t);
    end
  endtask

  // Random part at one phase length. Mostly whole transactions (start,
  // address byte, a few data bytes, stop) with random content; the rest are
  // lone commands with heavier noise. squeeze asks the receiver for one long
  // hold right away, while the sender keeps offering ticks.
  task automatic run_random_phase(input logic [TICK_W-1:0] pt, input int budget,
                                  input bit squeeze);
    int first_tick;
    int n_ops;
    settle();
    apb_access(1'b1, APB_DATA_W'(pt));
    apb_access(1'b0, '0);
    first_tick = ticks_sent;
    if (squeeze) hold_asked <= hold_asked + 1;
    while (ticks_sent - first_tick < budget) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) != 0) begin
        run_command(OP_START, rnd_byte(), rnd_bit(), 5, 1'b0, $urandom_range(0, 2));
        run_command(OP_WRITE, rnd_byte(), rnd_bit(), 5, rnd_bit(), $urandom_range(0, 2));
        n_ops = $urandom_range(0, 3);
        for (int k = 0; k < n_ops; k++) begin
          if ($urandom_range(0, 1)) begin
            run_command(OP_WRITE, rnd_byte(), rnd_bit(), 5, rnd_bit(),
                        $urandom_range(0, 2));
          end else begin
            // ACK every byte but the last, which may go either way.
            run_command(OP_READ, rnd_byte(), (k != n_ops - 1) ? 1'b1 : rnd_bit(), 5,
                        rnd_bit(), $urandom_range(0, 2));
          end
        end
        run_command(OP_STOP, rnd_byte(), rnd_bit(), 5, rnd_bit(), $urandom_range(0, 3));
      end else begin
        run_command(op_t'($urandom_range(0, 3)), rnd_byte(), rnd_bit(), 30, rnd_bit(),
                    $urandom_range(0, 3));
      end
    end
  endtask

  // Hard ceiling on the run.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset value reads back, and one start runs at the reset phase length.
    apb_access(1'b0, '0);
    run_command(OP_START, 8'h00, 1'b1, 0, 1'b0, 1);

    // Zero phase length runs as one tick. Walk every command at least once:
    // all-ones and all-zeros bytes, read with ACK and with NACK, a start
    // straight after a NACK (SCL left low), stray commands while busy and on
    // the completing tick.
    settle();
    apb_access(1'b1, 32'd0);
    apb_access(1'b0, '0);
    run_command(OP_START, 8'h5A, 1'b0, 0, 1'b0, 0);
    run_command(OP_WRITE, 8'hFF, 1'b0, 0, 1'b0, 1);
    run_command(OP_WRITE, 8'h00, 1'b1, 0, 1'b1, 0);
    run_command(OP_READ, 8'hFF, 1'b1, 0, 1'b0, 0);
    run_command(OP_READ, 8'h00, 1'b0, 0, 1'b1, 2);
    run_command(OP_START, 8'hFF, 1'b1, 0, 1'b0, 0);
    run_command(OP_WRITE, 8'hA5, 1'b0, 50, 1'b0, 0);
    run_command(OP_STOP, 8'h00, 1'b0, 0, 1'b1, 1);

    // Largest phase length, then cut it to one in the middle of a phase: the
    // running phase must end on the next tick and the start finish quickly.
    settle();
    apb_access(1'b1, 32'hFFFF);
    apb_access(1'b0, '0);
    run_command(OP_START, 8'h00, 1'b1, 0, 1'b0, -65535 * 3 + 30);
    settle();
    apb_access(1'b1, 32'd1);
    apb_access(1'b0, '0);
    repeat (5) put_tick(idle_tick());

    // Random part over short phase lengths; the first phase forces the
    // input side to back up behind a long output hold.
    run_random_phase(16'd1, 300, 1'b1);
    run_random_phase(16'd2, 250, 1'b0);
    run_random_phase(16'd3, 200, 1'b0);

    settle();
    $display("tb: %0d tick transfers driven, %0d commands completed", ticks_sent, completions);
    $display("tb: phase lengths 50, 0, 65535 cut to 1 mid-phase, then 1, 2 and 3 at random");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ibe_pkg.sv
hdl/ibe_front.sv
hdl/ibe_back.sv
hdl/i2c_master_byte_engine.sv
test/ibe_line_check.sv
test/tb_top.sv
